@@ rtl/mono_framebuffer_text_renderer_core_assert.svh @@
// Assertion shorthands for the frame store core.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef MONO_FRAMEBUFFER_TEXT_RENDERER_CORE_ASSERT_SVH
`define MONO_FRAMEBUFFER_TEXT_RENDERER_CORE_ASSERT_SVH

// same-cycle implication
`define MFB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mfb_pkg.sv @@
`timescale 1ns / 1ps

package mfb_pkg;

    // panel geometry, eight vertical pixels per byte
    localparam int C_PANEL_WIDTH  = 128;
    localparam int C_PANEL_HEIGHT = 64;
    localparam int C_PAGES        = (C_PANEL_HEIGHT + 7) / 8;
    localparam int C_STORE_BYTES  = C_PANEL_WIDTH * C_PAGES;
    localparam int C_ADDR_W       = $clog2(C_STORE_BYTES);

    // coordinate width: holds col + width sums and row + height sums
    localparam int C_XW    = 9;
    // width used for address math and range compares
    localparam int C_CMP_W = 16;

    // opcodes
    localparam logic [2:0] OP_FILL   = 3'd0;
    localparam logic [2:0] OP_CURSOR = 3'd1;
    localparam logic [2:0] OP_PIXEL  = 3'd2;
    localparam logic [2:0] OP_GLYPH  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // configuration port
    localparam int C_CFG_IDX_W  = 2;
    localparam int C_CFG_DATA_W = 7;
    localparam logic [C_CFG_IDX_W-1:0] REG_INVERT = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] REG_FONT_W = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] REG_FONT_H = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic        color;
        logic [15:0] glyph_bits;
        logic [5:0]  glyph_row;
        logic        last_row;
        logic [9:0]  byte_index;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] read_data;
        logic       accepted;
        logic [7:0] cursor_column;
    } t_out_beat;

    // pixel unit result
    typedef struct packed {
        logic                in_bounds;
        logic [C_ADDR_W-1:0] addr;
        logic [7:0]          mask;
    } t_pix_res;

endpackage

@@ rtl/mono_framebuffer_text_renderer_core.sv @@
`timescale 1ns / 1ps

// Channel  | Signals                               | Direction
// ---------+---------------------------------------+----------
// in       | i_in_valid, o_in_stall, i_in_data     | beat in
// out      | o_out_valid, i_out_stall, o_out_data  | beat out
// cfg      | i_cfg_we, i_cfg_idx, i_cfg_data       | write only
//
// Sequencer around one pixel unit and a frame store RAM with registered read.
// Per beat: glyph row S_PIX per pixel (one read-modify-write per pixel, overlapped)
// then S_DRAIN; draw pixel S_PIX, S_DRAIN; read byte S_RD, S_RD_CAP; fill a sweep;
// others, a clipped pixel and a refused or zero-width glyph row go straight to S_DONE.
// After reset a sweep clears the store; input stalls meanwhile.
// A result waits in the output register while the next beat is taken; a
// stalled output only holds back the completion of the following result.
module mono_framebuffer_text_renderer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mfb_pkg::t_in_beat                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mfb_pkg::t_out_beat                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [mfb_pkg::C_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mfb_pkg::C_CFG_DATA_W-1:0]  i_cfg_data
);
    import mfb_pkg::*;

`include "mono_framebuffer_text_renderer_core_assert.svh"

    // sequencer states
    localparam logic [2:0] S_SWEEP  = 3'd0;  // fill / post-reset clear
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PIX    = 3'd2;  // read pixel byte, write previous
    localparam logic [2:0] S_DRAIN  = 3'd3;  // write last pending byte
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_RD_CAP = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // control
    logic [2:0]  r_state, n_state;
    logic        r_report, n_report;
    logic        r_wpend, n_wpend;
    logic        r_out_valid, n_out_valid;
    logic [C_ADDR_W-1:0] r_cnt, n_cnt;
    logic [7:0]  r_ccol, n_ccol;
    logic [7:0]  r_crow, n_crow;
    logic        r_inv;
    logic [4:0]  r_fw;
    logic [6:0]  r_fh;

    // payload
    logic [C_XW-1:0] r_x, n_x;
    logic [C_XW-1:0] r_y, n_y;
    logic [15:0] r_bits, n_bits;
    logic        r_color, n_color;
    logic [4:0]  r_left, n_left;
    logic        r_pen, n_pen;
    logic        r_pcolor, n_pcolor;
    logic [C_ADDR_W-1:0] r_wa, n_wa;
    logic [7:0]  r_mask, n_mask;
    logic [7:0]  r_fill, n_fill;
    logic [C_ADDR_W-1:0] r_bidx, n_bidx;
    logic [7:0]  r_rd, n_rd;
    logic        r_acc, n_acc;
    t_out_beat   r_out, n_out;

    // datapath wires
    t_pix_res            w_pix;
    logic                w_we;
    logic [C_ADDR_W-1:0] w_waddr;
    logic [7:0]          w_wdata;
    logic [C_ADDR_W-1:0] w_raddr;
    logic [7:0]          w_rdata;
    logic                w_take;
    logic                w_out_free;
    logic                w_pix_in;
    logic                w_fit;
    logic                w_rd_in;

    mfb_pix_unit u_pix (
        .i_x   (r_x),
        .i_y   (r_y),
        .o_res (w_pix)
    );

    mfb_ram #(
        .WIDTH (8),
        .DEPTH (C_STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_take      = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // store ports: sweep writes the fill byte, otherwise read-modify-write
    assign w_we    = (r_state == S_SWEEP) || (r_wpend && r_pen);
    assign w_waddr = (r_state == S_SWEEP) ? r_cnt : r_wa;
    assign w_wdata = (r_state == S_SWEEP) ? r_fill :
                     (r_pcolor ? (w_rdata | r_mask) : (w_rdata & ~r_mask));
    assign w_raddr = (r_state == S_PIX) ? w_pix.addr : r_bidx;

    // entry checks
    assign w_pix_in = ({1'b0, i_in_data.pos_x} < C_XW'(C_PANEL_WIDTH)) &&
                      ({1'b0, i_in_data.pos_y} < C_XW'(C_PANEL_HEIGHT));
    assign w_fit    = ((C_XW'(r_ccol) + C_XW'(r_fw)) < C_XW'(C_PANEL_WIDTH)) &&
                      ((C_XW'(r_crow) + C_XW'(r_fh)) < C_XW'(C_PANEL_HEIGHT));
    assign w_rd_in  = C_CMP_W'(i_in_data.byte_index) < C_CMP_W'(C_STORE_BYTES);

    always_comb begin
        n_state     = r_state;
        n_report    = r_report;
        n_wpend     = r_wpend;
        n_cnt       = r_cnt;
        n_ccol      = r_ccol;
        n_crow      = r_crow;
        n_x         = r_x;
        n_y         = r_y;
        n_bits      = r_bits;
        n_color     = r_color;
        n_left      = r_left;
        n_pen       = r_pen;
        n_pcolor    = r_pcolor;
        n_wa        = r_wa;
        n_mask      = r_mask;
        n_fill      = r_fill;
        n_bidx      = r_bidx;
        n_rd        = r_rd;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_SWEEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == C_ADDR_W'(C_STORE_BYTES - 1)) begin
                    n_state  = r_report ? S_DONE : S_IDLE;
                    n_report = 1'b0;
                end
            end
            S_IDLE: begin
                if (w_take) begin
                    n_rd    = 8'h00;
                    n_acc   = 1'b0;
                    n_color = i_in_data.color;
                    n_state = S_DONE;
                    case (i_in_data.opcode)
                        OP_FILL: begin
                            n_fill   = {8{i_in_data.color}};
                            n_cnt    = '0;
                            n_report = 1'b1;
                            n_acc    = 1'b1;
                            n_state  = S_SWEEP;
                        end
                        OP_CURSOR: begin
                            n_ccol = i_in_data.pos_x;
                            n_crow = i_in_data.pos_y;
                            n_acc  = 1'b1;
                        end
                        OP_PIXEL: begin
                            n_acc  = w_pix_in;
                            n_x    = C_XW'(i_in_data.pos_x);
                            n_y    = C_XW'(i_in_data.pos_y);
                            n_bits = 16'h8000;  // one "on" pixel: draws color
                            n_left = 5'd1;
                            if (w_pix_in) begin
                                n_state = S_PIX;
                            end
                        end
                        OP_GLYPH: begin
                            n_acc  = w_fit;
                            n_x    = C_XW'(r_ccol);
                            n_y    = C_XW'(r_crow) + C_XW'(i_in_data.glyph_row);
                            n_bits = i_in_data.glyph_bits;
                            n_left = r_fw;
                            if (w_fit) begin
                                if (i_in_data.last_row) begin
                                    n_ccol = r_ccol + 8'(r_fw);
                                end
                                if (r_fw != 5'd0) begin
                                    n_state = S_PIX;
                                end
                            end
                        end
                        OP_READ: begin
                            n_acc  = w_rd_in;
                            n_bidx = C_ADDR_W'(i_in_data.byte_index);
                            if (w_rd_in) begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_acc = 1'b0;
                        end
                    endcase
                end
            end
            S_PIX: begin
                // read this pixel's byte; the pending one is written meanwhile
                n_wpend  = 1'b1;
                n_wa     = w_pix.addr;
                n_mask   = w_pix.mask;
                n_pen    = w_pix.in_bounds;
                n_pcolor = (r_bits[15] ? r_color : ~r_color) ^ r_inv;
                n_x      = r_x + 1'b1;
                n_bits   = {r_bits[14:0], 1'b0};  // past bit 0: clear pixels
                n_left   = r_left - 1'b1;
                if (r_left == 5'd1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_wpend = 1'b0;
                n_state = S_DONE;
            end
            S_RD: begin
                n_state = S_RD_CAP;
            end
            S_RD_CAP: begin
                n_rd    = w_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out.read_data     = r_rd;
                    n_out.accepted      = r_acc;
                    n_out.cursor_column = r_ccol;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;  // clear the store first
            r_report    <= 1'b0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_ccol      <= 8'd0;
            r_crow      <= 8'd0;
            r_inv       <= 1'b0;
            r_fw        <= 5'd7;
            r_fh        <= 7'd10;
        end else begin
            r_state     <= n_state;
            r_report    <= n_report;
            r_wpend     <= n_wpend;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_ccol      <= n_ccol;
            r_crow      <= n_crow;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INVERT: r_inv <= i_cfg_data[0];
                    REG_FONT_W: r_fw  <= i_cfg_data[4:0];
                    REG_FONT_H: r_fh  <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers (fill byte is cleared so the reset sweep writes zero)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 8'h00;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_bits   <= n_bits;
        r_color  <= n_color;
        r_left   <= n_left;
        r_pen    <= n_pen;
        r_pcolor <= n_pcolor;
        r_wa     <= n_wa;
        r_mask   <= n_mask;
        r_bidx   <= n_bidx;
        r_rd     <= n_rd;
        r_acc    <= n_acc;
        r_out    <= n_out;
    end

    // checks
    `MFB_ASSERT_IMPL(a_no_write_idle, r_state == S_IDLE, !w_we, "store written while idle")
    `MFB_ASSERT_NEXT(a_busy_after_take, w_take, o_in_stall, "input taken twice in a row")
    `MFB_ASSERT_IMPL(a_write_in_store, w_we, C_CMP_W'(w_waddr) < C_CMP_W'(C_STORE_BYTES), "write past store")
    `MFB_ASSERT_NEXT(a_done_posts, (r_state == S_DONE) && w_out_free, o_out_valid && !o_in_stall, "result not posted")

endmodule

@@ rtl/mfb_ram.sv @@
`timescale 1ns / 1ps

module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mfb_pix_unit.sv @@
`timescale 1ns / 1ps

// Pixel to store mapping: clip, byte address, bit mask.
module mfb_pix_unit (
    input  logic [mfb_pkg::C_XW-1:0] i_x,
    input  logic [mfb_pkg::C_XW-1:0] i_y,
    output mfb_pkg::t_pix_res        o_res
);
    import mfb_pkg::*;

    logic [C_CMP_W-1:0] w_lin;

    // page * width + column; constant multiplier
    assign w_lin = C_CMP_W'(i_y[C_XW-1:3]) * C_CMP_W'(C_PANEL_WIDTH) + C_CMP_W'(i_x);

    assign o_res.in_bounds = (i_x < C_XW'(C_PANEL_WIDTH)) && (i_y < C_XW'(C_PANEL_HEIGHT));
    assign o_res.addr      = w_lin[C_ADDR_W-1:0];
    assign o_res.mask      = 8'(1) << i_y[2:0];

endmodule
